// File: rtl/core/png_stored_rgba_encoder_core_macros.svh
// ----------------------------------------------------------------------------
// png_stored_rgba_encoder_core_macros
// Assertion helpers for the stored-deflate PNG encoder core.
// ----------------------------------------------------------------------------
`ifndef PNG_STORED_RGBA_ENCODER_CORE_MACROS_SVH
`define PNG_STORED_RGBA_ENCODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PNGSE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define PNGSE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PNGSE_ASSERT_NOW(label, clk, rstn, ante, cons)
`define PNGSE_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/pngse_pkg.sv
// ----------------------------------------------------------------------------
// pngse_pkg
// Shared types, constants and the byte-wise CRC-32 for the PNG encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pngse_pkg;

    localparam int DIM_W       = 13;
    localparam int COL_W       = 15;
    localparam int RAW_W       = 27;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [DIM_W-1:0] MAX_WIDTH  = 13'd4096;
    localparam logic [DIM_W-1:0] MAX_HEIGHT = 13'd4096;
    localparam logic [15:0]      BLOCK_MAX  = 16'hffff;

    localparam logic [31:0] CRC_POLY = 32'hedb88320;
    localparam logic [31:0] CRC_INIT = 32'hffffffff;
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    // one queued image byte with its framing flags
    typedef struct packed {
        logic [7:0] data;
        logic       hdr;
        logic       row_start;
        logic       last;
    } item_t;

    // one byte through the reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pngse_front.sv
// ----------------------------------------------------------------------------
// pngse_front
// Accepts image bytes and tags them with header, row start and last flags.
// ----------------------------------------------------------------------------
`default_nettype none

module pngse_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_pixel_byte,
    input  wire logic [pngse_pkg::DIM_W-1:0]    image_width,
    input  wire logic [pngse_pkg::DIM_W-1:0]    image_height,
    input  wire logic                           q_full,
    output logic                                q_push,
    output pngse_pkg::item_t                    q_item,
    output logic                                started
);

    logic                         started_reg, started_next;
    logic [pngse_pkg::COL_W-1:0]  col_reg, col_next;
    logic [pngse_pkg::DIM_W-1:0]  row_reg, row_next;
    logic [pngse_pkg::COL_W-1:0]  col_inc;
    logic [pngse_pkg::COL_W-1:0]  row_bytes;
    logic [pngse_pkg::DIM_W-1:0]  row_inc;
    logic                         row_done;
    logic                         file_done;

    assign s_ready   = !q_full;
    assign q_push    = s_valid && !q_full;
    assign started   = started_reg;

    // position bookkeeping
    assign row_bytes = {image_width, 2'b00};
    assign col_inc   = col_reg + 1'b1;
    assign row_done  = (col_inc >= row_bytes);
    assign row_inc   = row_done ? row_reg + 1'b1 : row_reg;
    assign file_done = (row_inc >= image_height);

    always_comb begin
        q_item.data      = s_pixel_byte;
        q_item.hdr       = !started_reg;
        q_item.row_start = (col_reg == '0);
        q_item.last      = file_done;
        started_next     = started_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        if (q_push) begin
            if (file_done) begin
                started_next = 1'b0;
                col_next     = '0;
                row_next     = '0;
            end else begin
                started_next = 1'b1;
                col_next     = row_done ? '0 : col_inc;
                row_next     = row_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
        end else begin
            started_reg <= started_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pngse_queue.sv
// ----------------------------------------------------------------------------
// pngse_queue
// Small FIFO of tagged items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pngse_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire pngse_pkg::item_t    push_item,
    input  wire logic                pop,
    output pngse_pkg::item_t         pop_item,
    output logic                     full,
    output logic                     empty,
    output logic [$clog2(pngse_pkg::QUEUE_DEPTH):0] count
);

    localparam int PTR_W = $clog2(pngse_pkg::QUEUE_DEPTH);

    pngse_pkg::item_t  mem_reg [pngse_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [PTR_W:0]    cnt_reg, cnt_next;

    assign full     = (cnt_reg == (PTR_W+1)'(pngse_pkg::QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign count    = cnt_reg;
    assign pop_item = mem_reg[rd_reg];

    // pointer update
    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop  ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pngse_back.sv
// ----------------------------------------------------------------------------
// pngse_back
// Byte sequencer: header, stored block framing, raw bytes, trailer, CRC, Adler.
// ----------------------------------------------------------------------------
`default_nettype none

module pngse_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [pngse_pkg::DIM_W-1:0]    image_width,
    input  wire logic [pngse_pkg::DIM_W-1:0]    image_height,
    input  wire logic                           q_empty,
    input  wire pngse_pkg::item_t               q_item,
    output logic                                q_pop,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [7:0]                          m_out_byte,
    output logic                                m_last_of_file
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_BLK,
        ST_RAW,
        ST_TRL
    } state_t;

    localparam int RAW_W = pngse_pkg::RAW_W;

    state_t                    state_reg, state_next;
    logic [5:0]                cnt_reg, cnt_next;
    pngse_pkg::item_t          cur_reg, cur_next;
    logic                      filt_reg, filt_next;
    logic [RAW_W-1:0]          raw_total_reg, raw_total_next;
    logic [31:0]               zlen_reg, zlen_next;
    logic [RAW_W-1:0]          raw_left_reg, raw_left_next;
    logic [15:0]               blk_left_reg, blk_left_next;
    logic [31:0]               crc_reg, crc_next;
    logic [15:0]               adl_lo_reg, adl_lo_next;
    logic [15:0]               adl_hi_reg, adl_hi_next;
    logic                      m_valid_reg, m_valid_next;
    logic [7:0]                m_byte_reg, m_byte_next;
    logic                      m_last_reg, m_last_next;

    logic                      advance;
    logic                      emit;
    logic [7:0]                ob;
    logic                      use_crc;
    logic                      crc_init;
    logic                      ob_last;
    logic [31:0]               crc_out;
    logic [31:0]               adler;
    logic [15:0]               blk_size;
    logic                      blk_final;
    logic [15:0]               blk_nsize;
    logic [27:0]               ceil_y;
    logic [16:0]               ceil_r;
    logic [11:0]               blocks;
    logic [14:0]               row_len;
    logic [7:0]                raw_b;
    logic [16:0]               lo_sum;
    logic [15:0]               lo_mod;
    logic [16:0]               hi_sum;
    logic [15:0]               hi_mod;
    logic [15:0]               blk_dec;

    assign advance        = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_out_byte     = m_byte_reg;
    assign m_last_of_file = m_last_reg;

    assign crc_out   = crc_reg ^ pngse_pkg::CRC_INIT;
    assign adler     = {adl_hi_reg, adl_lo_reg};
    assign row_len   = {image_width, 2'b00} + 15'd1;

    // stored block size from the raw bytes still to come
    assign blk_final = (raw_left_reg <= RAW_W'(pngse_pkg::BLOCK_MAX));
    assign blk_size  = blk_final ? raw_left_reg[15:0] : pngse_pkg::BLOCK_MAX;
    assign blk_nsize = ~blk_size;
    assign blk_dec   = (blk_left_reg != '0) ? blk_left_reg - 1'b1 : blk_left_reg;

    // ceil(raw_total / 65535) by one fold and one correction
    assign ceil_y = {1'b0, raw_total_reg} + 28'd65534;
    assign ceil_r = {1'b0, ceil_y[15:0]} + {5'd0, ceil_y[27:16]};
    assign blocks = ceil_y[27:16] + 12'(ceil_r >= 17'd65535);

    // adler-32 byte update
    assign raw_b  = filt_reg ? 8'd0 : cur_reg.data;
    assign lo_sum = {1'b0, adl_lo_reg} + {9'd0, raw_b};
    assign lo_mod = (lo_sum >= pngse_pkg::ADLER_MOD) ? 16'(lo_sum - pngse_pkg::ADLER_MOD)
                                                     : lo_sum[15:0];
    assign hi_sum = {1'b0, adl_hi_reg} + {1'b0, lo_mod};
    assign hi_mod = (hi_sum >= pngse_pkg::ADLER_MOD) ? 16'(hi_sum - pngse_pkg::ADLER_MOD)
                                                     : hi_sum[15:0];

    // byte selection per state and step
    always_comb begin
        ob       = 8'h00;
        use_crc  = 1'b0;
        crc_init = 1'b0;
        ob_last  = 1'b0;
        emit     = 1'b1;
        case (state_reg)
            ST_HDR: begin
                case (cnt_reg)
                    6'd0:  ob = 8'h89;
                    6'd1:  ob = 8'h50;
                    6'd2:  ob = 8'h4e;
                    6'd3:  ob = 8'h47;
                    6'd4:  ob = 8'h0d;
                    6'd5:  ob = 8'h0a;
                    6'd6:  ob = 8'h1a;
                    6'd7:  ob = 8'h0a;
                    6'd11: ob = 8'h0d;
                    6'd12: begin ob = 8'h49; use_crc = 1'b1; crc_init = 1'b1; end
                    6'd13: begin ob = 8'h48; use_crc = 1'b1; end
                    6'd14: begin ob = 8'h44; use_crc = 1'b1; end
                    6'd15: begin ob = 8'h52; use_crc = 1'b1; end
                    6'd18: begin ob = {3'd0, image_width[12:8]}; use_crc = 1'b1; end
                    6'd19: begin ob = image_width[7:0]; use_crc = 1'b1; end
                    6'd22: begin ob = {3'd0, image_height[12:8]}; use_crc = 1'b1; end
                    6'd23: begin ob = image_height[7:0]; use_crc = 1'b1; end
                    6'd24: begin ob = 8'h08; use_crc = 1'b1; end
                    6'd25: begin ob = 8'h06; use_crc = 1'b1; end
                    6'd16, 6'd17, 6'd20, 6'd21, 6'd26, 6'd27, 6'd28: begin
                        ob = 8'h00; use_crc = 1'b1;
                    end
                    6'd29: ob = crc_out[31:24];
                    6'd30: ob = crc_out[23:16];
                    6'd31: ob = crc_out[15:8];
                    6'd32: ob = crc_out[7:0];
                    6'd33: ob = zlen_reg[31:24];
                    6'd34: ob = zlen_reg[23:16];
                    6'd35: ob = zlen_reg[15:8];
                    6'd36: ob = zlen_reg[7:0];
                    6'd37: begin ob = 8'h49; use_crc = 1'b1; crc_init = 1'b1; end
                    6'd38: begin ob = 8'h44; use_crc = 1'b1; end
                    6'd39: begin ob = 8'h41; use_crc = 1'b1; end
                    6'd40: begin ob = 8'h54; use_crc = 1'b1; end
                    6'd41: begin ob = 8'h78; use_crc = 1'b1; end
                    6'd42: begin ob = 8'h01; use_crc = 1'b1; end
                    default: ob = 8'h00;
                endcase
            end
            ST_BLK: begin
                use_crc = 1'b1;
                case (cnt_reg)
                    6'd0:    ob = {7'd0, blk_final};
                    6'd1:    ob = blk_size[7:0];
                    6'd2:    ob = blk_size[15:8];
                    6'd3:    ob = blk_nsize[7:0];
                    default: ob = blk_nsize[15:8];
                endcase
            end
            ST_RAW: begin
                ob      = raw_b;
                use_crc = 1'b1;
            end
            ST_TRL: begin
                case (cnt_reg)
                    6'd0:  begin ob = adler[31:24]; use_crc = 1'b1; end
                    6'd1:  begin ob = adler[23:16]; use_crc = 1'b1; end
                    6'd2:  begin ob = adler[15:8];  use_crc = 1'b1; end
                    6'd3:  begin ob = adler[7:0];   use_crc = 1'b1; end
                    6'd4:  ob = crc_out[31:24];
                    6'd5:  ob = crc_out[23:16];
                    6'd6:  ob = crc_out[15:8];
                    6'd7:  ob = crc_out[7:0];
                    6'd12: begin ob = 8'h49; use_crc = 1'b1; crc_init = 1'b1; end
                    6'd13: begin ob = 8'h45; use_crc = 1'b1; end
                    6'd14: begin ob = 8'h4e; use_crc = 1'b1; end
                    6'd15: begin ob = 8'h44; use_crc = 1'b1; end
                    6'd16: ob = crc_out[31:24];
                    6'd17: ob = crc_out[23:16];
                    6'd18: ob = crc_out[15:8];
                    6'd19: begin ob = crc_out[7:0]; ob_last = 1'b1; end
                    default: ob = 8'h00;
                endcase
            end
            default: emit = 1'b0;
        endcase
    end

    // sequencer next state
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        filt_next      = filt_reg;
        raw_total_next = raw_total_reg;
        zlen_next      = zlen_reg;
        raw_left_next  = raw_left_reg;
        blk_left_next  = blk_left_reg;
        crc_next       = crc_reg;
        adl_lo_next    = adl_lo_reg;
        adl_hi_next    = adl_hi_reg;
        m_valid_next   = m_valid_reg;
        m_byte_next    = m_byte_reg;
        m_last_next    = m_last_reg;
        q_pop          = 1'b0;
        if (advance) begin
            m_valid_next = emit;
            m_byte_next  = ob;
            m_last_next  = ob_last;
            if (emit && use_crc) begin
                crc_next = pngse_pkg::crc_byte(crc_init ? pngse_pkg::CRC_INIT : crc_reg, ob);
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        q_pop     = 1'b1;
                        cur_next  = q_item;
                        filt_next = q_item.row_start;
                        cnt_next  = '0;
                        if (q_item.hdr) begin
                            state_next = ST_HDR;
                        end else if (blk_left_reg == '0) begin
                            state_next = ST_BLK;
                        end else begin
                            state_next = ST_RAW;
                        end
                    end
                end
                ST_HDR: begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 6'd0) begin
                        raw_total_next = RAW_W'(row_len) * RAW_W'(image_height);
                    end
                    if (cnt_reg == 6'd1) begin
                        zlen_next     = 32'(raw_total_reg) + 32'd6
                                      + {18'd0, blocks, 2'b00} + {20'd0, blocks};
                        raw_left_next = raw_total_reg;
                        blk_left_next = '0;
                        adl_lo_next   = 16'd1;
                        adl_hi_next   = 16'd0;
                    end
                    if (cnt_reg == 6'd42) begin
                        cnt_next   = '0;
                        state_next = ST_BLK;
                    end
                end
                ST_BLK: begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 6'd4) begin
                        blk_left_next = blk_size;
                        cnt_next      = '0;
                        state_next    = ST_RAW;
                    end
                end
                ST_RAW: begin
                    adl_lo_next   = lo_mod;
                    adl_hi_next   = hi_mod;
                    raw_left_next = (raw_left_reg != '0) ? raw_left_reg - 1'b1 : raw_left_reg;
                    blk_left_next = blk_dec;
                    cnt_next      = '0;
                    if (filt_reg) begin
                        filt_next  = 1'b0;
                        state_next = (blk_dec == '0) ? ST_BLK : ST_RAW;
                    end else if (cur_reg.last) begin
                        state_next = ST_TRL;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
                ST_TRL: begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 6'd19) begin
                        cnt_next      = '0;
                        state_next    = ST_IDLE;
                        crc_next      = pngse_pkg::CRC_INIT;
                        adl_lo_next   = 16'd1;
                        adl_hi_next   = 16'd0;
                        raw_left_next = '0;
                        blk_left_next = '0;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            filt_reg      <= 1'b0;
            raw_left_reg  <= '0;
            blk_left_reg  <= '0;
            crc_reg       <= pngse_pkg::CRC_INIT;
            adl_lo_reg    <= 16'd1;
            adl_hi_reg    <= 16'd0;
            m_valid_reg   <= 1'b0;
            m_last_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            filt_reg      <= filt_next;
            raw_left_reg  <= raw_left_next;
            blk_left_reg  <= blk_left_next;
            crc_reg       <= crc_next;
            adl_lo_reg    <= adl_lo_next;
            adl_hi_reg    <= adl_hi_next;
            m_valid_reg   <= m_valid_next;
            m_last_reg    <= m_last_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        raw_total_reg <= raw_total_next;
        zlen_reg      <= zlen_next;
        m_byte_reg    <= m_byte_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/png_stored_rgba_encoder_core.sv
// ----------------------------------------------------------------------------
// png_stored_rgba_encoder_core
// Streams RGBA8 image bytes into a complete PNG file using stored deflate.
// ----------------------------------------------------------------------------
// Usage: write image_width (index 0) and image_height (index 1) through
// cfg_we/cfg_index/cfg_wdata while no image is in flight, then feed the
// image bytes in raster order on s_valid/s_ready/s_pixel_byte.
// The file bytes leave on m_valid/m_ready/m_out_byte; m_last_of_file marks
// the final IEND CRC byte, after which the next input byte starts a new file.
// The first byte of an image produces 43 header bytes, then block framing,
// filter byte and data. Throughput: the output sequencer emits one byte
// per cycle while m_ready is high, and fetches each queued item in an idle
// state that emits no byte; a row start adds a filter byte, a stored block
// header five bytes and the trailer twenty bytes.
// A four-entry item queue lets input continue while the output stalls;
// when m_ready is low the output byte holds and the queue fills, then
// s_ready drops.
// Reset clears the position counters and queue, returns the CRC and Adler
// state to their initial values and sets both dimensions to one.
// ----------------------------------------------------------------------------
`default_nettype none
`include "png_stored_rgba_encoder_core_macros.svh"

module png_stored_rgba_encoder_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [pngse_pkg::DIM_W-1:0]  cfg_wdata,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [7:0]                   s_pixel_byte,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [7:0]                        m_out_byte,
    output logic                              m_last_of_file
);

    logic [pngse_pkg::DIM_W-1:0] width_reg, width_next;
    logic [pngse_pkg::DIM_W-1:0] height_reg, height_next;
    logic [pngse_pkg::DIM_W-1:0] cfg_val;
    logic                        started;
    logic                        q_push;
    logic                        q_pop;
    logic                        q_full;
    logic                        q_empty;
    logic [$clog2(pngse_pkg::QUEUE_DEPTH):0] q_count;
    pngse_pkg::item_t            q_in;
    pngse_pkg::item_t            q_out;

    // dimension registers, zero stored as one
    assign cfg_val = (cfg_wdata == '0) ? pngse_pkg::DIM_W'(1) : cfg_wdata;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we && !started) begin
            case (cfg_index)
                pngse_pkg::REG_WIDTH: begin
                    width_next = (cfg_val > pngse_pkg::MAX_WIDTH) ? pngse_pkg::MAX_WIDTH
                                                                  : cfg_val;
                end
                pngse_pkg::REG_HEIGHT: begin
                    height_next = (cfg_val > pngse_pkg::MAX_HEIGHT) ? pngse_pkg::MAX_HEIGHT
                                                                    : cfg_val;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= pngse_pkg::DIM_W'(1);
            height_reg <= pngse_pkg::DIM_W'(1);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    pngse_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_byte (s_pixel_byte),
        .image_width  (width_reg),
        .image_height (height_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_in),
        .started      (started)
    );

    pngse_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .pop_item  (q_out),
        .full      (q_full),
        .empty     (q_empty),
        .count     (q_count)
    );

    pngse_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .image_width    (width_reg),
        .image_height   (height_reg),
        .q_empty        (q_empty),
        .q_item         (q_out),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last_of_file (m_last_of_file)
    );

    // checks
    `PNGSE_ASSERT_NEXT(a_cfg_locked, aclk, aresetn, cfg_we && started, $stable(width_reg) && $stable(height_reg))
    `PNGSE_ASSERT_NOW(a_queue_bound, aclk, aresetn, 1'b1, q_count <= ($clog2(pngse_pkg::QUEUE_DEPTH)+1)'(pngse_pkg::QUEUE_DEPTH))
    `PNGSE_ASSERT_NOW(a_no_pop_empty, aclk, aresetn, q_pop, !q_empty)

endmodule

`default_nettype wire
